>>> rtl/sm4_pkg.sv
// sm4_pkg: constants, s-box table and round helper functions for the sm4 cipher core
// used by sm4_cbc_block_cipher_core; depends on nothing else
package sm4_pkg;

   localparam int ROUNDS = 32;
   localparam int RIDX_W = $clog2(ROUNDS);

   // configuration port
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam logic [2:0] REG_KEY_HIGH = 3'd0;
   localparam logic [2:0] REG_KEY_LOW  = 3'd1;
   localparam logic [2:0] REG_IV_HIGH  = 3'd2;
   localparam logic [2:0] REG_IV_LOW   = 3'd3;
   localparam logic [2:0] REG_DECRYPT  = 3'd4;
   localparam logic [2:0] REG_CHAINING = 3'd5;

   typedef logic [31:0] word_type;

   localparam word_type FK0 = 32'ha3b1bac6;
   localparam word_type FK1 = 32'h56aa3350;
   localparam word_type FK2 = 32'h677d9197;
   localparam word_type FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // byte-wise s-box substitution
   function automatic word_type tau(input word_type x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   // data path linear transform: b ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24
   function automatic word_type l_crypt(input word_type b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   // key schedule linear transform: b ^ rotl13 ^ rotl23
   function automatic word_type l_key(input word_type b);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // ck byte j of round i is 7 * (4i + j) mod 256
   function automatic word_type ck_word(input logic [RIDX_W-1:0] i);
      word_type   w;
      logic [7:0] n;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         n = {1'b0, i, 2'(j)};
         w = {w[23:0], 8'(n * 8'd7)};
      end
      return w;
   endfunction

endpackage

>>> rtl/sm4_cbc_block_cipher_core.sv
// sm4_cbc_block_cipher_core: sm4 block cipher, ecb or cbc, with on-chip key schedule
// depends on sm4_pkg
//
// usage
//  - req channel (valid/ready): one 128-bit block per beat, split into block_high
//    (bytes 0..7) and block_low (bytes 8..15), plus restart_chain to reload the
//    chain value from the iv before the block is used
//  - rsp channel (valid/ready): one 128-bit result beat per request beat
//  - csr port (apb style, 64-bit data, register i at byte address 8*i): key, iv,
//    decrypt and chaining mode; write only while the core is idle
//  - a block runs its 32 rounds, one per cycle, through the single shared round unit
//    (xor, s-box, linear transform), then a finish state for the output and chain
//    update; req_ready rises together with rsp valid, so a new block is accepted
//    only after the last one has left the round loop
//  - a write to either key register starts a key expansion on the same round unit:
//    a start step and 32 rounds, with req_ready low until it is done
//  - reset clears the csr registers (chaining resets to cbc), the chain value and
//    the rsp valid flag, then expands the all-zero key with req_ready low
//  - when the receiver stalls, the result waits in the rsp register; the next block
//    may be accepted and runs its rounds, but it is held in the finish cycle until
//    the pending result beat has been taken
module sm4_cbc_block_cipher_core #(
   parameter int ROUNDS = sm4_pkg::ROUNDS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [63:0]                 req_block_high,
   input  logic [63:0]                 req_block_low,
   input  logic                        req_restart_chain,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [63:0]                 rsp_result_high,
   output logic [63:0]                 rsp_result_low,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sm4_pkg::CSR_AW-1:0]  paddr,
   input  logic [sm4_pkg::CSR_DW-1:0]  pwdata,
   output logic [sm4_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   localparam int RIDX_W = $clog2(ROUNDS);
   localparam logic [RIDX_W-1:0] LAST_RND = RIDX_W'(ROUNDS - 1);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_KEYX  = 2'd1;
   localparam logic [1:0] S_CRYPT = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   // csr registers
   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic        decrypt_ff, chaining_ff;
   logic        kx_pend_ff, kx_pend_in;

   // sequencer and data path state
   logic [1:0]           state_ff, state_in;
   logic [RIDX_W-1:0]    cnt_ff, cnt_in;
   sm4_pkg::word_type    x_ff [4];
   sm4_pkg::word_type    x_in [4];
   logic [63:0]          blk_high_ff, blk_high_in, blk_low_ff, blk_low_in;
   logic [63:0]          chain_high_ff, chain_high_in, chain_low_ff, chain_low_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_high_ff, rsp_high_in, rsp_low_ff, rsp_low_in;
   sm4_pkg::word_type    rk_ff [ROUNDS];
   logic                 rk_we;

   logic              csr_wr, key_wr, load_key, req_take, fin_take;
   logic [2:0]        csr_idx;
   logic [RIDX_W-1:0] rk_idx;
   sm4_pkg::word_type rk_word, t_word, b_word, nx_word;
   logic [63:0]       cv_high, cv_low, rev_high, rev_low;

   // ---------------------------------------------------------------- csr port
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[5:3];
   assign key_wr  = csr_wr && (csr_idx inside {sm4_pkg::REG_KEY_HIGH, sm4_pkg::REG_KEY_LOW});

   always_comb begin
      case (csr_idx)
         sm4_pkg::REG_KEY_HIGH: prdata = key_high_ff;
         sm4_pkg::REG_KEY_LOW:  prdata = key_low_ff;
         sm4_pkg::REG_IV_HIGH:  prdata = iv_high_ff;
         sm4_pkg::REG_IV_LOW:   prdata = iv_low_ff;
         sm4_pkg::REG_DECRYPT:  prdata = {63'd0, decrypt_ff};
         sm4_pkg::REG_CHAINING: prdata = {63'd0, chaining_ff};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
         decrypt_ff  <= 1'b0;
         chaining_ff <= 1'b1;
      end else if (csr_wr) begin
         case (csr_idx)
            sm4_pkg::REG_KEY_HIGH: key_high_ff <= pwdata;
            sm4_pkg::REG_KEY_LOW:  key_low_ff  <= pwdata;
            sm4_pkg::REG_IV_HIGH:  iv_high_ff  <= pwdata;
            sm4_pkg::REG_IV_LOW:   iv_low_ff   <= pwdata;
            sm4_pkg::REG_DECRYPT:  decrypt_ff  <= pwdata[0];
            sm4_pkg::REG_CHAINING: chaining_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- shared round unit
   // decryption walks the round keys backwards
   assign rk_idx  = decrypt_ff ? (LAST_RND - cnt_ff) : cnt_ff;
   assign rk_word = (state_ff == S_KEYX) ? sm4_pkg::ck_word(cnt_ff) : rk_ff[rk_idx];
   assign t_word  = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ rk_word;
   assign b_word  = sm4_pkg::tau(t_word);
   assign nx_word = x_ff[0] ^ ((state_ff == S_KEYX) ? sm4_pkg::l_key(b_word)
                                                    : sm4_pkg::l_crypt(b_word));

   // final word reversal
   assign rev_high = {x_ff[3], x_ff[2]};
   assign rev_low  = {x_ff[1], x_ff[0]};

   // chain value seen by the accepted block
   assign cv_high = req_restart_chain ? iv_high_ff : chain_high_ff;
   assign cv_low  = req_restart_chain ? iv_low_ff  : chain_low_ff;

   // --------------------------------------------------------------- sequencer
   assign req_ready = (state_ff == S_IDLE) && !kx_pend_ff;
   assign req_take  = req_valid && req_ready;
   assign load_key  = kx_pend_ff && (state_ff inside {S_IDLE, S_KEYX});
   assign fin_take  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // a key write during a load keeps the request pending
   assign kx_pend_in = key_wr || (kx_pend_ff && !load_key);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      blk_high_in   = blk_high_ff;
      blk_low_in    = blk_low_ff;
      chain_high_in = chain_high_ff;
      chain_low_in  = chain_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;
      rk_we         = 1'b0;

      if (load_key) begin
         // start (or restart) the key schedule from the key registers
         x_in[0]  = key_high_ff[63:32] ^ sm4_pkg::FK0;
         x_in[1]  = key_high_ff[31:0]  ^ sm4_pkg::FK1;
         x_in[2]  = key_low_ff[63:32]  ^ sm4_pkg::FK2;
         x_in[3]  = key_low_ff[31:0]   ^ sm4_pkg::FK3;
         cnt_in   = '0;
         state_in = S_KEYX;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  chain_high_in = cv_high;
                  chain_low_in  = cv_low;
                  blk_high_in   = req_block_high;
                  blk_low_in    = req_block_low;
                  if (chaining_ff && !decrypt_ff) begin
                     // cbc encrypt whitens the input with the chain value
                     x_in[0] = req_block_high[63:32] ^ cv_high[63:32];
                     x_in[1] = req_block_high[31:0]  ^ cv_high[31:0];
                     x_in[2] = req_block_low[63:32]  ^ cv_low[63:32];
                     x_in[3] = req_block_low[31:0]   ^ cv_low[31:0];
                  end else begin
                     x_in[0] = req_block_high[63:32];
                     x_in[1] = req_block_high[31:0];
                     x_in[2] = req_block_low[63:32];
                     x_in[3] = req_block_low[31:0];
                  end
                  cnt_in   = '0;
                  state_in = S_CRYPT;
               end
            end
            S_KEYX: begin
               rk_we   = 1'b1;
               x_in[0] = x_ff[1];
               x_in[1] = x_ff[2];
               x_in[2] = x_ff[3];
               x_in[3] = nx_word;
               if (cnt_ff == LAST_RND) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            S_CRYPT: begin
               x_in[0] = x_ff[1];
               x_in[1] = x_ff[2];
               x_in[2] = x_ff[3];
               x_in[3] = nx_word;
               if (cnt_ff == LAST_RND) begin
                  cnt_in   = '0;
                  state_in = S_FIN;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            S_FIN: begin
               // wait for the rsp register, then post-process and chain
               if (fin_take) begin
                  if (chaining_ff && decrypt_ff) begin
                     rsp_high_in   = rev_high ^ chain_high_ff;
                     rsp_low_in    = rev_low  ^ chain_low_ff;
                     chain_high_in = blk_high_ff;
                     chain_low_in  = blk_low_ff;
                  end else begin
                     rsp_high_in = rev_high;
                     rsp_low_in  = rev_low;
                     if (chaining_ff) begin
                        chain_high_in = rev_high;
                        chain_low_in  = rev_low;
                     end
                  end
                  state_in = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || fin_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         kx_pend_ff    <= 1'b1;   // expand the reset key
         chain_high_ff <= '0;
         chain_low_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         kx_pend_ff    <= kx_pend_in;
         chain_high_ff <= chain_high_in;
         chain_low_ff  <= chain_low_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      blk_high_ff <= blk_high_in;
      blk_low_ff  <= blk_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
      if (rk_we) begin
         rk_ff[cnt_ff] <= nx_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low  = rsp_low_ff;

endmodule

>>> tb/sm4_cbc_block_cipher_core_test.sv
// self-checking testbench for sm4_cbc_block_cipher_core: ecb/cbc encrypt and decrypt
// checked beat by beat against an in-bench sm4 model with its own key schedule and chain
// depends on sm4_pkg and the core rtl only
module sm4_cbc_block_cipher_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits and pacing
   localparam int LIMIT_CYCLES      = 600000;
   localparam int CLEAR_PASS_CYCLES = 40;    // zero-key expansion after reset
   localparam int KEY_SETTLE_CYCLES = 40;    // key expansion after a key write
   localparam int BLOCK_LATENCY     = 34;
   localparam int LONG_HOLD_CYCLES  = 400;
   localparam int RANDOM_PHASES     = 10;
   localparam int BLOCKS_PER_PHASE  = 83;

   // register slots past the end of the map, writes there must be dropped
   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   // standard sm4 test vector key, also used as the plaintext
   localparam logic [63:0] STD_KEY_HIGH = 64'h0123456789abcdef;
   localparam logic [63:0] STD_KEY_LOW  = 64'hfedcba9876543210;

   typedef enum int {ALWAYS_READY, MOSTLY_READY, MOSTLY_STALLED, PERIODIC} ready_pattern_type;

   // mirror of the cipher: registers, round keys, chain value and the blocks still owed
   class sm4_cbc_mirror_type;
      localparam int NR = 32;
      bit [127:0] sbox_rows [16];
      bit [31:0]  round_key [NR];
      bit [63:0]  key_hi, key_lo;
      bit [127:0] iv_val, chain_val;
      bit         decrypt_mode, cbc_mode;
      bit [127:0] expected_blocks [$];
      int         failures;

      function new();
         sbox_rows = '{
            128'hd690e9fe_cce13db7_16b614c2_28fb2c05, 128'h2b679a76_2abe04c3_aa441326_49860699,
            128'h9c4250f4_91ef987a_33540b43_edcfac62, 128'he4b31ca9_c908e895_80df94fa_758f3fa6,
            128'h4707a7fc_f37317ba_83593c19_e6854fa8, 128'h686b81b2_7164da8b_f8eb0f4b_70569d35,
            128'h1e240e5e_6358d1a2_25227c3b_01217887, 128'hd4004657_9fd32752_4c3602e7_a0c4c89e,
            128'heabf8ad2_40c738b5_a3f7f2ce_f96115a1, 128'he0ae5da4_9b341a55_ad933230_f58cb1e3,
            128'h1df6e22e_8266ca60_c02923ab_0d534e6f, 128'hd5db3745_defd8e2f_03ff6a72_6d6c5b51,
            128'h8d1baf92_bbddbc7f_11d95c41_1f105ad8, 128'h0ac13188_a5cd7bbd_2d74d012_b8e5b4b0,
            128'h8969974a_0c96777e_65b9f109_c56ec684, 128'h18f07dec_3adc4d20_79ee5f3e_d7cb3948
         };
         key_hi       = '0;
         key_lo       = '0;
         iv_val       = '0;
         chain_val    = '0;
         decrypt_mode = 1'b0;
         cbc_mode     = 1'b1;
         failures     = 0;
         build_schedule();
      endfunction

      function bit [7:0] sbox_byte(bit [7:0] v);
         bit [127:0] row;
         int         col;
         row = sbox_rows[v[7:4]];
         col = 15 - int'(v[3:0]);
         return row[8*col +: 8];
      endfunction

      function bit [31:0] sub_word(bit [31:0] x);
         return {sbox_byte(x[31:24]), sbox_byte(x[23:16]), sbox_byte(x[15:8]),
                 sbox_byte(x[7:0])};
      endfunction

      function bit [31:0] rotl(bit [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      // key schedule: fk whitening, ck constants, 13/23 rotation transform
      function void build_schedule();
         bit [31:0] k [4];
         bit [31:0] ck, b, nk;
         k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
         k[1] = key_hi[31:0]  ^ 32'h56aa3350;
         k[2] = key_lo[63:32] ^ 32'h677d9197;
         k[3] = key_lo[31:0]  ^ 32'hb27022dc;
         for (int i = 0; i < NR; i++) begin
            ck = '0;
            for (int j = 0; j < 4; j++) begin
               ck = {ck[23:0], 8'((4 * i + j) * 7)};
            end
            b  = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
            round_key[i] = nk;
         end
      endfunction

      // 32 rounds, round keys reversed for decryption, output words reversed
      function bit [127:0] sm4_rounds(bit [127:0] blk, bit dec);
         bit [31:0] x [4];
         bit [31:0] rk, b, nx;
         x[0] = blk[127:96];
         x[1] = blk[95:64];
         x[2] = blk[63:32];
         x[3] = blk[31:0];
         for (int r = 0; r < NR; r++) begin
            rk = dec ? round_key[NR - 1 - r] : round_key[r];
            b  = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
         end
         return {x[3], x[2], x[1], x[0]};
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] value);
         case (idx)
            sm4_pkg::REG_KEY_HIGH: begin
               key_hi = value;
               build_schedule();
            end
            sm4_pkg::REG_KEY_LOW: begin
               key_lo = value;
               build_schedule();
            end
            sm4_pkg::REG_IV_HIGH:  iv_val[127:64] = value;
            sm4_pkg::REG_IV_LOW:   iv_val[63:0]   = value;
            sm4_pkg::REG_DECRYPT:  decrypt_mode   = value[0];
            sm4_pkg::REG_CHAINING: cbc_mode       = value[0];
            default: ;
         endcase
      endfunction

      // request beat taken: work out the block it owes
      function void accept_block(bit [63:0] hi, bit [63:0] lo, bit restart);
         bit [127:0] blk, res;
         blk = {hi, lo};
         if (restart) begin
            chain_val = iv_val;
         end
         if (!cbc_mode) begin
            res = sm4_rounds(blk, decrypt_mode);
         end else if (!decrypt_mode) begin
            res       = sm4_rounds(blk ^ chain_val, 1'b0);
            chain_val = res;
         end else begin
            res       = sm4_rounds(blk, 1'b1) ^ chain_val;
            chain_val = blk;
         end
         expected_blocks.insert(expected_blocks.size(), res);
      endfunction

      // result beat taken: compare against the oldest owed block
      function void compare_block(bit [63:0] hi, bit [63:0] lo);
         bit [127:0] exp_blk;
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result beat, got %h %h", $time, hi, lo);
            failures++;
            return;
         end
         exp_blk = expected_blocks.pop_front();
         if (hi !== exp_blk[127:64]) begin
            $display("%0t: result_high mismatch, expected %h, got %h",
                     $time, exp_blk[127:64], hi);
            failures++;
         end
         if (lo !== exp_blk[63:0]) begin
            $display("%0t: result_low mismatch, expected %h, got %h",
                     $time, exp_blk[63:0], lo);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_blocks.size();
      endfunction
   endclass

   // clock, reset and every block input start at a known value
   logic                       clock;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic [63:0]                req_block_high    = '0;
   logic [63:0]                req_block_low     = '0;
   logic                       req_restart_chain = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic [63:0]                rsp_result_high;
   logic [63:0]                rsp_result_low;
   logic                       psel              = 1'b0;
   logic                       penable           = 1'b0;
   logic                       pwrite            = 1'b0;
   logic [sm4_pkg::CSR_AW-1:0] paddr             = '0;
   logic [sm4_pkg::CSR_DW-1:0] pwdata            = '0;
   logic [sm4_pkg::CSR_DW-1:0] prdata;
   logic                       pready;

   sm4_cbc_mirror_type cipher_mirror;

   // sender pacing: bursts of beats with random gaps, or back to back
   bit gaps_on;
   int burst_left;
   // set by the stimulus once, the receiver then holds off for a long stretch
   bit long_hold_req = 1'b0;
   int cycle_count;

   sm4_cbc_block_cipher_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_block_high    (req_block_high),
      .req_block_low     (req_block_low),
      .req_restart_chain (req_restart_chain),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_high   (rsp_result_high),
      .rsp_result_low    (rsp_result_low),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sm4_cbc_block_cipher_core_test: FAIL");
      $finish;
   end

   // both channels are sampled at the edge, before any nonblocking update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            cipher_mirror.accept_block(req_block_high, req_block_low, req_restart_chain);
         end
         if (rsp_valid && rsp_ready) begin
            cipher_mirror.compare_block(rsp_result_high, rsp_result_low);
         end
      end
   end

   // receiver: switches between stall patterns, plus one long hold-off on request
   initial begin
      ready_pattern_type ready_mode;
      int                mode_left;
      int                tick;
      ready_mode = ALWAYS_READY;
      mode_left  = 0;
      tick       = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (long_hold_req) begin
            // block fills up: one result parked, the next one stuck in its finish cycle
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_pattern_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (ready_mode)
               ALWAYS_READY:   rsp_ready <= 1'b1;
               MOSTLY_READY:   rsp_ready <= ($urandom_range(0, 3) != 0);
               MOSTLY_STALLED: rsp_ready <= ($urandom_range(0, 3) == 0);
               PERIODIC:       rsp_ready <= ((tick % 7) < 3);
               default:        rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // random word that now and then lands on an extreme
   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one-bit register value with junk in the upper bits, only bit 0 counts
   function automatic logic [63:0] wide_flag(input bit flag);
      return {$urandom, 31'($urandom), flag};
   endfunction

   // apb write: setup cycle, access cycle, then the bus goes back to idle
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cipher_mirror.write_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      // key expansion runs on the shared round unit, let it finish
      if (idx inside {sm4_pkg::REG_KEY_HIGH, sm4_pkg::REG_KEY_LOW}) begin
         repeat (KEY_SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   // offer one request beat and hold it until taken, then maybe pause
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic restart);
      int gap;
      req_valid         <= 1'b1;
      req_block_high    <= hi;
      req_block_low     <= lo;
      req_restart_chain <= restart;
      do @(posedge clock); while (!req_ready);
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 11);
            gap        = $urandom_range(0, 40);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // stop offering and wait until every owed result beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cipher_mirror.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int   msg_left;
      logic restart;
      cipher_mirror = new();
      gaps_on       = 1'b1;
      burst_left    = 0;
      msg_left      = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // the core expands the all-zero key right after reset
      repeat (CLEAR_PASS_CYCLES) @(posedge clock);

      // reset defaults: zero key, zero iv, cbc encrypt
      send_block('0, '0, 1'b1);
      send_block('1, '1, 1'b0);
      send_block({4{16'h5555}}, {4{16'haaaa}}, 1'b0);
      send_block(64'h8000_0000_0000_0000, 64'h1, 1'b1);
      drain_results();

      // standard key in ecb, iv all ones; a restart in ecb still reloads the chain
      csr_write(sm4_pkg::REG_KEY_HIGH, STD_KEY_HIGH);
      csr_write(sm4_pkg::REG_KEY_LOW, STD_KEY_LOW);
      csr_write(sm4_pkg::REG_IV_HIGH, '1);
      csr_write(sm4_pkg::REG_IV_LOW, '1);
      csr_write(sm4_pkg::REG_CHAINING, 64'h0);
      send_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b0);
      send_block('0, '0, 1'b1);
      send_block('1, '1, 1'b0);
      drain_results();

      // back to cbc without a restart: chain is the iv picked up during ecb
      csr_write(sm4_pkg::REG_CHAINING, wide_flag(1'b1));
      send_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b0);
      send_block(pick_word(), pick_word(), 1'b0);
      drain_results();

      // cbc decrypt
      csr_write(sm4_pkg::REG_DECRYPT, wide_flag(1'b1));
      send_block(pick_word(), pick_word(), 1'b1);
      send_block('1, '1, 1'b0);
      send_block('0, '0, 1'b0);
      drain_results();

      // ecb decrypt with all-ones key and zero iv; spare slots must not disturb anything
      csr_write(sm4_pkg::REG_CHAINING, wide_flag(1'b0));
      csr_write(sm4_pkg::REG_KEY_HIGH, '1);
      csr_write(sm4_pkg::REG_KEY_LOW, '1);
      csr_write(sm4_pkg::REG_IV_HIGH, '0);
      csr_write(sm4_pkg::REG_IV_LOW, '0);
      csr_write(REG_SPARE_A, {$urandom, $urandom});
      csr_write(REG_SPARE_B, '1);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      send_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b0);
      send_block(pick_word(), pick_word(), 1'b0);
      drain_results();

      // random phases: fresh settings, then messages that open with a restart
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            csr_write(sm4_pkg::REG_KEY_HIGH, pick_word());
            csr_write(sm4_pkg::REG_KEY_LOW, pick_word());
         end
         if ($urandom_range(0, 1) == 1) begin
            csr_write(sm4_pkg::REG_IV_HIGH, pick_word());
            csr_write(sm4_pkg::REG_IV_LOW, pick_word());
         end
         csr_write(sm4_pkg::REG_DECRYPT, wide_flag(1'($urandom_range(0, 1))));
         csr_write(sm4_pkg::REG_CHAINING, wide_flag($urandom_range(0, 3) != 0));
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            // back to back beats against a long receiver hold-off
            gaps_on       = 1'b0;
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
            if (msg_left == 0) begin
               restart  = 1'b1;
               msg_left = $urandom_range(1, 12);
            end else begin
               // stray restarts break a message in the middle
               restart = ($urandom_range(0, 9) == 0);
            end
            msg_left--;
            send_block(pick_word(), pick_word(), restart);
         end
         drain_results();
      end

      repeat (2 * BLOCK_LATENCY) @(posedge clock);
      if (cipher_mirror.failures == 0 && cipher_mirror.outstanding() == 0) begin
         $display("sm4_cbc_block_cipher_core_test: PASS");
      end else begin
         $display("sm4_cbc_block_cipher_core_test: FAIL");
      end
      $finish;
   end

endmodule
